@@ src/assert_macros.svh @@
// Assertion macros used by the checker file.
// No dependencies; take it in by include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, disabled in reset
`define CHK_PROP(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("grid checker: property failed");

// condition that must never hold
`define CHK_NEVER(name, clk, rst, cond) `CHK_PROP(name, clk, rst, !(cond))

`endif

@@ src/gcb_pkg.sv @@
// Shared types and constants for the grid cell binning block.
// No dependencies.
package gcb_pkg;

   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_X       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_Y       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_Z       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CELL_EXTENT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CELLS_X     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CELLS_Y     = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_CELLS_Z     = 3'd6;

   localparam int CNT_W  = 9;
   localparam int EXT_W  = 31;
   localparam int IDX_W  = 24;
   localparam int SLOT_W = 5;

   localparam logic [SLOT_W-1:0] LAST_SLOT = 5'd26;

   localparam logic OP_BIN       = 1'b0;
   localparam logic OP_NEIGHBORS = 1'b1;

   typedef struct packed {
      logic signed [31:0] min_x;
      logic signed [31:0] min_y;
      logic signed [31:0] min_z;
      logic [EXT_W-1:0]   extent;
      logic [CNT_W-1:0]   nx;
      logic [CNT_W-1:0]   ny;
      logic [CNT_W-1:0]   nz;
   } grid_cfg_type;

endpackage

@@ src/gcb_front.sv @@
// Front end: accepts words and resolves cell coordinates in a divider pipeline.
// Depends on gcb_pkg.
module gcb_front import gcb_pkg::*; #(
   parameter int QW = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  grid_cfg_type       cfg,
   input  logic               start,
   input  logic               operation,
   input  logic signed [31:0] point_x,
   input  logic signed [31:0] point_y,
   input  logic signed [31:0] point_z,
   input  logic [IDX_W-1:0]   query_cell,
   input  logic               q_full,
   output logic               busy,
   output logic               q_push,
   output logic [3*QW+1:0]    q_wdata
);

   localparam int RW = 33 + QW;
   localparam int NS = 2 * QW + 2;

   typedef struct packed {
      logic                 vld;
      logic                 op;
      logic [2:0]           bad;
      logic [2:0][RW-1:0]   r;
      logic [2:0][QW-1:0]   q;
   } stg_type;

   stg_type stg_ff [NS];
   stg_type stg_in [NS];
   logic [2*CNT_W-1:0] nxy_ff;
   logic               stall;

   assign stall  = stg_ff[NS-1].vld && q_full;
   assign busy   = stall;
   assign q_push = stg_ff[NS-1].vld && !q_full;

   always_comb begin
      logic signed [32:0] d [3];
      d[0] = {point_x[31], point_x} - {cfg.min_x[31], cfg.min_x};
      d[1] = {point_y[31], point_y} - {cfg.min_y[31], cfg.min_y};
      d[2] = {point_z[31], point_z} - {cfg.min_z[31], cfg.min_z};
      stg_in[0].vld = start;
      stg_in[0].op  = operation;
      stg_in[0].q   = '0;
      if (operation == OP_BIN) begin
         for (int l = 0; l < 3; l++) begin
            stg_in[0].r[l]   = {{(RW-32){1'b0}}, d[l][31:0]};
            stg_in[0].bad[l] = d[l][32];
         end
      end else begin
         stg_in[0].r    = '0;
         stg_in[0].r[0] = {{(RW-IDX_W){1'b0}}, query_cell};
         stg_in[0].bad  = '0;
      end
   end

   // stage 1 tests for a quotient of 2**QW or more, then one bit per stage
   for (genvar s = 1; s < NS; s++) begin : g_stage
      if (s <= QW + 1) begin : g_ph1
         localparam int B = QW + 1 - s;
         always_comb begin
            logic [RW-1:0] dv;
            logic [RW-1:0] sh;
            stg_in[s] = stg_ff[s-1];
            dv = (stg_ff[s-1].op == OP_BIN) ? {{(RW-EXT_W){1'b0}}, cfg.extent}
                                             : {{(RW-2*CNT_W){1'b0}}, nxy_ff};
            sh = dv << B;
            for (int l = 0; l < 3; l++) begin
               if ((stg_ff[s-1].op == OP_BIN || l == 0) && stg_ff[s-1].r[l] >= sh) begin
                  if (s == 1) begin
                     stg_in[s].bad[l] = 1'b1;
                  end else begin
                     stg_in[s].q[l] = stg_ff[s-1].q[l] | (QW'(1) << B);
                     stg_in[s].r[l] = stg_ff[s-1].r[l] - sh;
                  end
               end
            end
         end
      end else begin : g_ph2
         localparam int B = 2 * QW + 1 - s;
         // remainder of the first division split by the row length
         always_comb begin
            logic [RW-1:0] sh;
            stg_in[s] = stg_ff[s-1];
            sh = {{(RW-CNT_W){1'b0}}, cfg.nx} << B;
            if (stg_ff[s-1].op == OP_NEIGHBORS && stg_ff[s-1].r[0] >= sh) begin
               stg_in[s].q[1] = stg_ff[s-1].q[1] | (QW'(1) << B);
               stg_in[s].r[0] = stg_ff[s-1].r[0] - sh;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      nxy_ff <= cfg.nx * cfg.ny;
      for (int s = 0; s < NS; s++) begin
         if (reset) begin
            stg_ff[s].vld <= 1'b0;
         end else if (!stall) begin
            stg_ff[s] <= stg_in[s];
         end
      end
   end

   always_comb begin
      logic              ok;
      logic [QW-1:0]     cx, cy, cz;
      stg_type           t;
      t = stg_ff[NS-1];
      if (t.op == OP_BIN) begin
         ok = !t.bad[0] && !t.bad[1] && !t.bad[2]
            && ({{CNT_W{1'b0}}, t.q[0]} < {{QW{1'b0}}, cfg.nx})
            && ({{CNT_W{1'b0}}, t.q[1]} < {{QW{1'b0}}, cfg.ny})
            && ({{CNT_W{1'b0}}, t.q[2]} < {{QW{1'b0}}, cfg.nz});
         cx = t.q[0];
         cy = t.q[1];
         cz = t.q[2];
      end else begin
         ok = !t.bad[0] && ({{CNT_W{1'b0}}, t.q[0]} < {{QW{1'b0}}, cfg.nz});
         cx = t.r[0][QW-1:0];
         cy = t.q[1];
         cz = t.q[0];
      end
      q_wdata = {t.op, ok, cz, cy, cx};
   end

endmodule

@@ src/gcb_queue.sv @@
// Four-entry word queue between the front end and the result sequencer.
// No package dependencies.
module gcb_queue #(
   parameter int W = 26
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  logic [W-1:0] wdata,
   input  logic         pop,
   output logic [W-1:0] rdata,
   output logic         full,
   output logic         empty
);

   localparam int DEPTH = 4;
   localparam int AW    = $clog2(DEPTH);

   logic [W-1:0]  mem_ff [DEPTH];
   logic [AW-1:0] wp_ff, rp_ff;
   logic [AW:0]   cnt_ff;

   assign full  = (cnt_ff == (AW+1)'(DEPTH));
   assign empty = (cnt_ff == '0);
   assign rdata = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wp_ff] <= wdata;
      end
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (push) begin
            wp_ff <= wp_ff + 1'b1;
         end
         if (pop) begin
            rp_ff <= rp_ff + 1'b1;
         end
         cnt_ff <= cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
      end
   end

endmodule

@@ src/gcb_back.sv @@
// Result sequencer: one result per cycle, 27 neighbor offsets or one bin result.
// Depends on gcb_pkg.
module gcb_back import gcb_pkg::*; #(
   parameter int QW = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  grid_cfg_type      cfg,
   input  logic              q_empty,
   input  logic [3*QW+1:0]   q_rdata,
   output logic              q_pop,
   output logic              rsp_valid,
   output logic [IDX_W-1:0]  rsp_cell_index,
   output logic              rsp_cell_valid,
   output logic [SLOT_W-1:0] rsp_neighbor_slot,
   output logic              rsp_last
);

   localparam int TW  = QW + CNT_W + 1;
   localparam int PW0 = TW + CNT_W + 1;
   localparam int PW  = (PW0 > IDX_W) ? PW0 : IDX_W;

   logic                cur_vld_ff;
   logic [3*QW+1:0]     cur_ff;
   logic [1:0]          ci_ff, cj_ff, ck_ff;
   logic [SLOT_W-1:0]   slot_ff;

   logic [QW-1:0]       cx, cy, cz;
   logic                cur_ok, is_bin, done;

   logic                v1_ff, ok1_ff, last1_ff;
   logic [QW-1:0]       ax1_ff, ay1_ff, az1_ff;
   logic [SLOT_W-1:0]   slot1_ff;

   logic                v2_ff, ok2_ff, last2_ff;
   logic [QW-1:0]       ax2_ff;
   logic [TW-1:0]       t2_ff;
   logic [SLOT_W-1:0]   slot2_ff;

   logic                e_ok;
   logic [QW-1:0]       e_ax, e_ay, e_az;
   logic [PW-1:0]       idx;

   assign cx     = cur_ff[QW-1:0];
   assign cy     = cur_ff[2*QW-1:QW];
   assign cz     = cur_ff[3*QW-1:2*QW];
   assign cur_ok = cur_ff[3*QW];
   assign is_bin = (cur_ff[3*QW+1] == OP_BIN);
   assign done   = cur_vld_ff && (is_bin || slot_ff == LAST_SLOT);
   assign q_pop  = (!cur_vld_ff || done) && !q_empty;

   // offset code 0..2 stands for -1..+1; bin uses the center
   always_comb begin
      logic [QW:0] sx, sy, sz;
      logic        inx, iny, inz;
      sx = {1'b0, cx} + (QW+1)'(is_bin ? 2'd1 : ci_ff);
      sy = {1'b0, cy} + (QW+1)'(is_bin ? 2'd1 : cj_ff);
      sz = {1'b0, cz} + (QW+1)'(is_bin ? 2'd1 : ck_ff);
      inx = (sx != '0) && ({{CNT_W{1'b0}}, sx} <= {{(QW+1){1'b0}}, cfg.nx});
      iny = (sy != '0) && ({{CNT_W{1'b0}}, sy} <= {{(QW+1){1'b0}}, cfg.ny});
      inz = (sz != '0) && ({{CNT_W{1'b0}}, sz} <= {{(QW+1){1'b0}}, cfg.nz});
      e_ok = cur_ok && inx && iny && inz;
      e_ax = QW'(sx - 1'b1);
      e_ay = QW'(sy - 1'b1);
      e_az = QW'(sz - 1'b1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_vld_ff <= 1'b0;
      end else if (q_pop) begin
         cur_vld_ff <= 1'b1;
         cur_ff     <= q_rdata;
         ci_ff      <= '0;
         cj_ff      <= '0;
         ck_ff      <= '0;
         slot_ff    <= '0;
      end else if (done) begin
         cur_vld_ff <= 1'b0;
      end else if (cur_vld_ff) begin
         slot_ff <= slot_ff + 1'b1;
         if (ci_ff == 2'd2) begin
            ci_ff <= '0;
            if (cj_ff == 2'd2) begin
               cj_ff <= '0;
               ck_ff <= ck_ff + 1'b1;
            end else begin
               cj_ff <= cj_ff + 1'b1;
            end
         end else begin
            ci_ff <= ci_ff + 1'b1;
         end
      end
   end

   assign idx = PW'(t2_ff) * PW'(cfg.nx) + PW'(ax2_ff);

   always_ff @(posedge clock) begin
      ok1_ff   <= e_ok;
      ax1_ff   <= e_ax;
      ay1_ff   <= e_ay;
      az1_ff   <= e_az;
      slot1_ff <= is_bin ? '0 : slot_ff;
      last1_ff <= done;

      ok2_ff   <= ok1_ff;
      ax2_ff   <= ax1_ff;
      t2_ff    <= TW'(az1_ff) * TW'(cfg.ny) + TW'(ay1_ff);
      slot2_ff <= slot1_ff;
      last2_ff <= last1_ff;

      rsp_cell_index    <= ok2_ff ? idx[IDX_W-1:0] : '0;
      rsp_cell_valid    <= ok2_ff;
      rsp_neighbor_slot <= slot2_ff;
      rsp_last          <= last2_ff;

      if (reset) begin
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         rsp_valid <= 1'b0;
      end else begin
         v1_ff     <= cur_vld_ff;
         v2_ff     <= v1_ff;
         rsp_valid <= v2_ff;
      end
   end

endmodule

@@ src/grid_cell_binning_and_neighbors.sv @@
// Channel   Ports                         Handshake
// request   start, busy, req_*            taken when start && !busy
// result    rsp_valid, rsp_*              valid marks each word, no backpressure
// csr       csr_p*                        write on psel & penable & pwrite
//
// Bin: one point per cycle while busy is low; each point passes through the
// per-bit divider pipeline in the front end.
// Neighbors: one word per neighbor offset, from the one-result-per-cycle sequencer.
// busy rises only when the four-entry queue is full and a word waits at the
// front end's output. Reset is synchronous; config registers return to defaults.
// Top level: CSR block, front end, queue and sequencer. Depends on gcb_pkg.
module grid_cell_binning_and_neighbors import gcb_pkg::*; #(
   parameter int MAX_CELLS_PER_AXIS = 256
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [4:0]         csr_paddr,
   input  logic [31:0]        csr_pwdata,
   output logic [31:0]        csr_prdata,
   output logic               csr_pready,
   input  logic               start,
   output logic               busy,
   input  logic               req_operation,
   input  logic signed [31:0] req_point_x,
   input  logic signed [31:0] req_point_y,
   input  logic signed [31:0] req_point_z,
   input  logic [IDX_W-1:0]   req_query_cell,
   output logic               rsp_valid,
   output logic [IDX_W-1:0]   rsp_cell_index,
   output logic               rsp_cell_valid,
   output logic [SLOT_W-1:0]  rsp_neighbor_slot,
   output logic               rsp_last
);

   localparam int QW  = $clog2(MAX_CELLS_PER_AXIS);
   localparam int QEW = 3 * QW + 2;

   logic [31:0]       min_x_ff, min_y_ff, min_z_ff;
   logic [EXT_W-1:0]  extent_ff;
   logic [CNT_W-1:0]  cells_x_ff, cells_y_ff, cells_z_ff;
   logic              csr_wr;
   logic [CSR_IDX_W-1:0] csr_idx;
   grid_cfg_type      cfg;

   logic              q_push, q_pop, q_full, q_empty;
   logic [QEW-1:0]    q_wdata, q_rdata;

   function automatic logic [CNT_W-1:0] eff_cnt(input logic [CNT_W-1:0] c);
      return (32'(c) > 32'(MAX_CELLS_PER_AXIS)) ? CNT_W'(MAX_CELLS_PER_AXIS) : c;
   endfunction

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_idx    = csr_paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         min_x_ff   <= '0;
         min_y_ff   <= '0;
         min_z_ff   <= '0;
         extent_ff  <= EXT_W'(65536);
         cells_x_ff <= CNT_W'(1);
         cells_y_ff <= CNT_W'(1);
         cells_z_ff <= CNT_W'(1);
      end else if (csr_wr) begin
         case (csr_idx)
            CSR_MIN_X:       min_x_ff   <= csr_pwdata;
            CSR_MIN_Y:       min_y_ff   <= csr_pwdata;
            CSR_MIN_Z:       min_z_ff   <= csr_pwdata;
            CSR_CELL_EXTENT: extent_ff  <= csr_pwdata[EXT_W-1:0];
            CSR_CELLS_X:     cells_x_ff <= csr_pwdata[CNT_W-1:0];
            CSR_CELLS_Y:     cells_y_ff <= csr_pwdata[CNT_W-1:0];
            CSR_CELLS_Z:     cells_z_ff <= csr_pwdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         CSR_MIN_X:       csr_prdata = min_x_ff;
         CSR_MIN_Y:       csr_prdata = min_y_ff;
         CSR_MIN_Z:       csr_prdata = min_z_ff;
         CSR_CELL_EXTENT: csr_prdata = 32'(extent_ff);
         CSR_CELLS_X:     csr_prdata = 32'(cells_x_ff);
         CSR_CELLS_Y:     csr_prdata = 32'(cells_y_ff);
         CSR_CELLS_Z:     csr_prdata = 32'(cells_z_ff);
         default:         csr_prdata = '0;
      endcase
   end

   assign cfg.min_x  = min_x_ff;
   assign cfg.min_y  = min_y_ff;
   assign cfg.min_z  = min_z_ff;
   assign cfg.extent = extent_ff;
   assign cfg.nx     = eff_cnt(cells_x_ff);
   assign cfg.ny     = eff_cnt(cells_y_ff);
   assign cfg.nz     = eff_cnt(cells_z_ff);

   gcb_front #(.QW(QW)) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .start      (start),
      .operation  (req_operation),
      .point_x    (req_point_x),
      .point_y    (req_point_y),
      .point_z    (req_point_z),
      .query_cell (req_query_cell),
      .q_full     (q_full),
      .busy       (busy),
      .q_push     (q_push),
      .q_wdata    (q_wdata)
   );

   gcb_queue #(.W(QEW)) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .pop   (q_pop),
      .rdata (q_rdata),
      .full  (q_full),
      .empty (q_empty)
   );

   gcb_back #(.QW(QW)) u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .q_empty           (q_empty),
      .q_rdata           (q_rdata),
      .q_pop             (q_pop),
      .rsp_valid         (rsp_valid),
      .rsp_cell_index    (rsp_cell_index),
      .rsp_cell_valid    (rsp_cell_valid),
      .rsp_neighbor_slot (rsp_neighbor_slot),
      .rsp_last          (rsp_last)
   );

endmodule

@@ src/gcb_checker.sv @@
// Port-level checks on the result channel, bound to the top level.
// Depends on gcb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module gcb_checker import gcb_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic [IDX_W-1:0]  rsp_cell_index,
   input logic              rsp_cell_valid,
   input logic [SLOT_W-1:0] rsp_neighbor_slot,
   input logic              rsp_last
);

   `CHK_PROP(a_invalid_zero, clock, reset, rsp_valid && !rsp_cell_valid |-> rsp_cell_index == '0)
   `CHK_NEVER(a_slot_range, clock, reset, rsp_valid && rsp_neighbor_slot > LAST_SLOT)
   `CHK_PROP(a_last_slot, clock, reset, rsp_valid && rsp_last && rsp_neighbor_slot != '0 |-> rsp_neighbor_slot == LAST_SLOT)
   `CHK_PROP(a_burst, clock, reset, rsp_valid && !rsp_last |=> rsp_valid && rsp_neighbor_slot == SLOT_W'($past(rsp_neighbor_slot) + 1'b1))

endmodule

bind grid_cell_binning_and_neighbors gcb_checker u_gcb_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_valid),
   .rsp_cell_index    (rsp_cell_index),
   .rsp_cell_valid    (rsp_cell_valid),
   .rsp_neighbor_slot (rsp_neighbor_slot),
   .rsp_last          (rsp_last)
);

@@ test/grid_cell_binning_and_neighbors_tb.sv @@
// Self-checking testbench for grid_cell_binning_and_neighbors: bin and neighbor
// words predicted in-bench and compared in order. Depends on gcb_pkg and the RTL.
module grid_cell_binning_and_neighbors_tb;
   import gcb_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_AXIS = 256;
   localparam int STALL_LIMIT = 4000;
   localparam int TAIL_CYCLES = 40;
   localparam int NUM_DIR = 14;
   localparam int ITEMS_PER_PHASE = 35;
   localparam int NUM_PHASES = 6;

   typedef struct {
      logic [IDX_W-1:0]  index;
      logic              valid;
      logic [SLOT_W-1:0] slot;
      logic              last;
   } cell_word_type;

   typedef struct {
      logic              op;
      logic [31:0]       px;
      logic [31:0]       py;
      logic [31:0]       pz;
      logic [IDX_W-1:0]  qc;
      bit                typed;
      logic [IDX_W-1:0]  t_index;
      logic              t_valid;
   } stim_row_type;

   logic clock, reset;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [4:0] csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;
   logic csr_pready;
   logic start, busy;
   logic req_operation;
   logic signed [31:0] req_point_x, req_point_y, req_point_z;
   logic [IDX_W-1:0] req_query_cell;
   logic rsp_valid;
   logic [IDX_W-1:0] rsp_cell_index;
   logic rsp_cell_valid;
   logic [SLOT_W-1:0] rsp_neighbor_slot;
   logic rsp_last;

   grid_cell_binning_and_neighbors dut (.*);

   // local copy of the grid registers
   logic signed [31:0] g_min [3];
   logic [EXT_W-1:0] g_extent;
   logic [CNT_W-1:0] g_cells [3];

   cell_word_type expected_words [$];
   int mismatches = 0;
   int stall_cycles = 0;
   int idle_pct = 0;

   stim_row_type dir_rows [NUM_DIR] = '{
      '{OP_BIN, 32'h0, 32'h0, 32'h0, 24'h0, 1'b1, 24'h0, 1'b1},
      '{OP_BIN, 32'h0000FFFF, 32'h0000FFFF, 32'h0000FFFF, 24'h0, 1'b1, 24'h0, 1'b1},
      '{OP_BIN, 32'h00010000, 32'h0, 32'h0, 24'h0, 1'b1, 24'h0, 1'b0},
      '{OP_BIN, 32'hFFFFFFFF, 32'h0, 32'h0, 24'h0, 1'b1, 24'h0, 1'b0},
      '{OP_BIN, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 24'h0, 1'b1, 24'h0, 1'b0},
      '{OP_BIN, 32'h80000000, 32'h80000000, 32'h80000000, 24'h0, 1'b1, 24'h0, 1'b0},
      '{OP_BIN, 32'h0, 32'h00010000, 32'h0, 24'h0, 1'b1, 24'h0, 1'b0},
      '{OP_BIN, 32'h0, 32'h0, 32'h80000000, 24'h0, 1'b1, 24'h0, 1'b0},
      '{OP_BIN, 32'h0, 32'h0, 32'h0, 24'hFFFFFF, 1'b1, 24'h0, 1'b1},
      '{OP_NEIGHBORS, 32'h0, 32'h0, 32'h0, 24'h0, 1'b0, 24'h0, 1'b0},
      '{OP_NEIGHBORS, 32'h0, 32'h0, 32'h0, 24'h1, 1'b0, 24'h0, 1'b0},
      '{OP_NEIGHBORS, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 24'hFFFFFF,
        1'b0, 24'h0, 1'b0},
      '{OP_NEIGHBORS, 32'h0, 32'h0, 32'h0, 24'h800000, 1'b0, 24'h0, 1'b0},
      '{OP_BIN, 32'h00008000, 32'h00004000, 32'h00002000, 24'h0, 1'b0, 24'h0, 1'b0}
   };

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic longint eff_cells(logic [CNT_W-1:0] c);
      return (c > MAX_AXIS) ? MAX_AXIS : longint'(c);
   endfunction

   function automatic bit axis_cell(logic signed [31:0] p, logic signed [31:0] mn,
                                    longint n, output longint c);
      longint d;
      d = longint'(p) - longint'(mn);
      c = 0;
      if (d < 0 || g_extent == 0 || n == 0) return 0;
      c = d / longint'(g_extent);
      return c < n;
   endfunction

   function automatic cell_word_type mk_word(longint idx, bit ok, int slot, bit lst);
      cell_word_type w;
      w.index = ok ? idx[IDX_W-1:0] : '0;
      w.valid = ok;
      w.slot = slot[SLOT_W-1:0];
      w.last = lst;
      return w;
   endfunction

   // expected words for one accepted request
   function automatic void predict_cells(logic op, logic [31:0] px, logic [31:0] py,
                                         logic [31:0] pz, logic [IDX_W-1:0] qc);
      longint nx, ny, nz, cx, cy, cz, total, ax, ay, az;
      bit ok;
      int n;
      nx = eff_cells(g_cells[0]);
      ny = eff_cells(g_cells[1]);
      nz = eff_cells(g_cells[2]);
      if (op == OP_BIN) begin
         ok = axis_cell(px, g_min[0], nx, cx);
         if (ok) ok = axis_cell(py, g_min[1], ny, cy);
         if (ok) ok = axis_cell(pz, g_min[2], nz, cz);
         expected_words.push_back(mk_word((cz * ny + cy) * nx + cx, ok, 0, 1'b1));
      end else begin
         total = nx * ny * nz;
         cx = 0; cy = 0; cz = 0;
         if (total != 0 && longint'(qc) < total) begin
            cx = qc % nx;
            cy = (qc / nx) % ny;
            cz = qc / (nx * ny);
         end
         n = 0;
         for (int k = -1; k <= 1; k++)
            for (int j = -1; j <= 1; j++)
               for (int i = -1; i <= 1; i++) begin
                  ax = cx + i; ay = cy + j; az = cz + k;
                  ok = total != 0 && longint'(qc) < total && ax >= 0 && ax < nx
                       && ay >= 0 && ay < ny && az >= 0 && az < nz;
                  expected_words.push_back(mk_word((az * ny + ay) * nx + ax, ok, n,
                                                   n == 26));
                  n++;
               end
      end
   endfunction

   // result monitor and watchdog
   always @(posedge clock) begin
      cell_word_type w;
      if (!reset) begin
         if ((start && !busy) || rsp_valid) stall_cycles <= 0;
         else stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
         if (rsp_valid) begin
            if (expected_words.size() == 0) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10) $display("unexpected word idx=%h", rsp_cell_index);
            end else begin
               w = expected_words.pop_front();
               if (rsp_cell_index !== w.index || rsp_cell_valid !== w.valid ||
                   rsp_neighbor_slot !== w.slot || rsp_last !== w.last) begin
                  mismatches <= mismatches + 1;
                  if (mismatches < 10)
                     $display("mismatch: exp idx=%h v=%b slot=%0d last=%b, got idx=%h v=%b slot=%0d last=%b",
                              w.index, w.valid, w.slot, w.last, rsp_cell_index,
                              rsp_cell_valid, rsp_neighbor_slot, rsp_last);
               end
            end
         end
      end
   end

   task automatic csr_write(int reg_idx, logic [31:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= 5'(reg_idx * 4);
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      case (reg_idx)
         CSR_MIN_X, CSR_MIN_Y, CSR_MIN_Z: g_min[reg_idx] = value;
         CSR_CELL_EXTENT: g_extent = value[EXT_W-1:0];
         CSR_CELLS_X, CSR_CELLS_Y, CSR_CELLS_Z: g_cells[reg_idx - 4] = value[CNT_W-1:0];
         default: ;
      endcase
   endtask

   task automatic drain();
      start <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task automatic send_item(stim_row_type r);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_operation <= r.op;
      req_point_x <= r.px;
      req_point_y <= r.py;
      req_point_z <= r.pz;
      req_query_cell <= r.qc;
      do @(posedge clock); while (busy);
      if (r.typed) expected_words.push_back(mk_word(r.t_index, r.t_valid, 0, 1'b1));
      else predict_cells(r.op, r.px, r.py, r.pz, r.qc);
   endtask

   function automatic logic [31:0] pick_coord(int axis);
      longint n, p;
      n = eff_cells(g_cells[axis]);
      if ($urandom_range(99) < 70 && n != 0 && g_extent != 0) begin
         p = longint'(g_min[axis]) + longint'($urandom_range(n - 1)) * g_extent
             + longint'($urandom_range(g_extent - 1));
         return p[31:0];
      end
      return $urandom;
   endfunction

   function automatic stim_row_type random_row();
      stim_row_type r;
      longint total;
      r.typed = 1'b0;
      r.t_index = '0;
      r.t_valid = 1'b0;
      r.op = $urandom_range(1);
      r.px = pick_coord(0);
      r.py = pick_coord(1);
      r.pz = pick_coord(2);
      total = eff_cells(g_cells[0]) * eff_cells(g_cells[1]) * eff_cells(g_cells[2]);
      if ($urandom_range(99) < 70 && total != 0)
         r.qc = IDX_W'($urandom_range(total - 1));
      else
         r.qc = IDX_W'($urandom);
      return r;
   endfunction

   initial begin
      int pct [NUM_PHASES];
      pct = '{0, 62, 0, 23, 62, 0};
      reset = 1'b1;
      csr_psel = 1'b0; csr_penable = 1'b0; csr_pwrite = 1'b0;
      csr_paddr = '0; csr_pwdata = '0;
      start = 1'b0; req_operation = OP_BIN;
      req_point_x = '0; req_point_y = '0; req_point_z = '0; req_query_cell = '0;
      g_min = '{0, 0, 0};
      g_extent = 31'd65536;
      g_cells = '{9'd1, 9'd1, 9'd1};
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (dir_rows[i]) send_item(dir_rows[i]);
      drain();

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         idle_pct = pct[ph];
         case (ph)
            0: begin
               // x count at the limit, saturated y count and widest cells from the most negative corner
               csr_write(CSR_MIN_X, 32'h80000000);
               csr_write(CSR_MIN_Y, 32'h80000000);
               csr_write(CSR_MIN_Z, 32'h80000000);
               csr_write(CSR_CELL_EXTENT, 32'h7FFFFFFF);
               csr_write(CSR_CELLS_X, 32'd256);
               csr_write(CSR_CELLS_Y, 32'd511);
               csr_write(CSR_CELLS_Z, 32'd2);
            end
            1: begin
               // zero extent, empty grid along z, top corner; bad index ignored
               csr_write(CSR_MIN_X, 32'h7FFFFFFF);
               csr_write(CSR_CELL_EXTENT, 32'd0);
               csr_write(CSR_CELLS_Z, 32'd0);
               csr_write(7, 32'hFFFFFFFF);
            end
            default: begin
               for (int a = 0; a < 3; a++)
                  csr_write(a, 32'($signed($urandom_range(2000000)) - 1000000));
               csr_write(CSR_CELL_EXTENT, $urandom_range(1, 32'h00200000));
               for (int a = 0; a < 3; a++)
                  csr_write(CSR_CELLS_X + a, ($urandom_range(3) == 0) ?
                            $urandom_range(257, 511) : $urandom_range(1, 12));
            end
         endcase
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            send_item(random_row());
            if (ph == 2 && n == ITEMS_PER_PHASE / 2) begin
               start <= 1'b0;
               while (expected_words.size() != 0) @(posedge clock);
            end
         end
         drain();
      end

      if (mismatches == 0 && expected_words.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
